// ----- rtl/core/efis_pkg.sv -----
`default_nettype none

package efis_pkg;

   // Field widths
   localparam int HpaWidth    = 11;
   localparam int InhgWidth   = 12;
   localparam int KHpaWidth   = 22;   // hPa per 0.01 inHg, Q16
   localparam int KInhgWidth  = 20;   // 0.01 inHg per hPa, Q16
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 32;
   localparam int WordWidth   = 32;

   // Register reset values
   localparam logic [HpaWidth-1:0]   MinHpaReset  = 11'd745;
   localparam logic [HpaWidth-1:0]   MaxHpaReset  = 11'd1100;
   localparam logic [InhgWidth-1:0]  MinInhgReset = 12'd2200;
   localparam logic [InhgWidth-1:0]  MaxInhgReset = 12'd3248;
   localparam logic [KHpaWidth-1:0]  KHpaReset    = 22'd22193;
   localparam logic [KInhgWidth-1:0] KInhgReset   = 20'd193528;

   // Baro state reset values
   localparam logic [HpaWidth-1:0]  HpaStdValue  = 11'd1013;
   localparam logic [InhgWidth-1:0] InhgStdValue = 12'd2992;

   // Saturation of converted values
   localparam logic [InhgWidth-1:0] HpaSat  = 12'd2047;
   localparam logic [InhgWidth-1:0] InhgSat = 12'd4095;

   // ARINC 429 sign/status matrix, normal operation
   localparam logic [1:0] SsmNormal = 2'b11;

   // Word positions (ARINC bit n sits at position n-1)
   localparam int PosSsmLo      = 29;
   localparam int PosSsmHi      = 30;
   localparam int PosUnitInhg   = 10;
   localparam int PosRange10    = 24;
   localparam int PosRange20    = 25;
   localparam int PosRange40    = 26;
   localparam int PosRange80    = 27;
   localparam int PosRange160   = 28;
   localparam int PosModePlan   = 10;
   localparam int PosModeArc    = 11;
   localparam int PosModeNav    = 12;
   localparam int PosModeVor    = 13;
   localparam int PosModeIls    = 14;
   localparam int PosFiltCstr   = 16;
   localparam int PosFiltWpt    = 17;
   localparam int PosFiltVord   = 18;
   localparam int PosFiltNdb    = 19;
   localparam int PosFiltArpt   = 20;
   localparam int PosLsOn       = 21;
   localparam int PosFdOff      = 22;
   localparam int PosNav1Adf    = 23;
   localparam int PosNav2Adf    = 24;
   localparam int PosNav1Vor    = 25;
   localparam int PosNav2Vor    = 26;
   localparam int PosStdOn      = 27;
   localparam int PosQfeOff     = 28;

   // Register indexes
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_MIN_HPA   = 3'd0,
      CSR_MAX_HPA   = 3'd1,
      CSR_MIN_INHG  = 3'd2,
      CSR_MAX_INHG  = 3'd3,
      CSR_K_HPA     = 3'd4,
      CSR_K_INHG    = 3'd5
   } csr_idx_type;

   typedef enum logic [2:0] {
      FILT_NONE = 3'd0,
      FILT_CSTR = 3'd1,
      FILT_WPT  = 3'd2,
      FILT_VORD = 3'd3,
      FILT_NDB  = 3'd4,
      FILT_ARPT = 3'd5
   } filter_type;

   typedef enum logic [2:0] {
      RANGE_10  = 3'd0,
      RANGE_20  = 3'd1,
      RANGE_40  = 3'd2,
      RANGE_80  = 3'd3,
      RANGE_160 = 3'd4
   } range_type;

   typedef enum logic [2:0] {
      MODE_ROSE_ILS = 3'd0,
      MODE_ROSE_VOR = 3'd1,
      MODE_ROSE_NAV = 3'd2,
      MODE_ARC      = 3'd3,
      MODE_PLAN     = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      NAVAID_OFF = 2'd0,
      NAVAID_ADF = 2'd1,
      NAVAID_VOR = 2'd2
   } navaid_type;

   // Limits and conversion factors
   typedef struct packed {
      logic [HpaWidth-1:0]   min_hpa;
      logic [HpaWidth-1:0]   max_hpa;
      logic [InhgWidth-1:0]  min_inhg_centi;
      logic [InhgWidth-1:0]  max_inhg_centi;
      logic [KHpaWidth-1:0]  hpa_per_inhg_centi_q16;
      logic [KInhgWidth-1:0] inhg_centi_per_hpa_q16;
   } efis_cfg_type;

   // Knob step request for one transaction
   typedef struct packed {
      logic en;
      logic dec;
      logic inc;
      logic is_inhg;
   } efis_step_type;

   // Baro setting in both units
   typedef struct packed {
      logic [HpaWidth-1:0]  hpa;
      logic [InhgWidth-1:0] inhg;
   } efis_baro_type;

   // Result transaction
   typedef struct packed {
      logic [WordWidth-1:0] word_one;
      logic [WordWidth-1:0] word_two;
      logic [HpaWidth-1:0]  baro_hpa_out;
      logic [InhgWidth-1:0] baro_inhg_out;
   } efis_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/efis_ifs.sv -----
`default_nettype none

// Panel tick channel
interface efis_req_if;
   logic       valid;
   logic       ready;
   logic       fd_button;
   logic       ls_button;
   logic [2:0] filter_button;
   logic       knob_pull;
   logic       knob_push;
   logic       knob_dec;
   logic       knob_inc;
   logic       unit_is_inhg;
   logic [2:0] range_sel;
   logic [2:0] mode_sel;
   logic [1:0] navaid_one_sel;
   logic [1:0] navaid_two_sel;

   modport source (
      output valid, fd_button, ls_button, filter_button, knob_pull, knob_push,
             knob_dec, knob_inc, unit_is_inhg, range_sel, mode_sel,
             navaid_one_sel, navaid_two_sel,
      input  ready
   );
   modport sink (
      input  valid, fd_button, ls_button, filter_button, knob_pull, knob_push,
             knob_dec, knob_inc, unit_is_inhg, range_sel, mode_sel,
             navaid_one_sel, navaid_two_sel,
      output ready
   );
endinterface

// Result channel
interface efis_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] word_one;
   logic [31:0] word_two;
   logic [10:0] baro_hpa_out;
   logic [11:0] baro_inhg_out;

   modport source (
      output valid, word_one, word_two, baro_hpa_out, baro_inhg_out,
      input  ready
   );
   modport sink (
      input  valid, word_one, word_two, baro_hpa_out, baro_inhg_out,
      output ready
   );
endinterface

// Register write channel
interface efis_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/efis_panel_baro_selector.sv -----
`default_nettype none

// Channel  Port    Dir  Transfers
// -------  ------  ---  ------------------------------------------------
// req      req_if  in   one panel tick (buttons, knob, selectors)
// rsp      rsp_if  out  two ARINC 429 discrete words, baro hPa and inHg
// csr      csr_if  in   limit / conversion register write, always ready
//
// One panel tick per cycle while req ready is high; results are registered.
// The baro step, clamp and Q16 conversion resolve in the same
// cycle as the tick, in the baro unit's single multiplier.
// Synchronous active-high reset restores the panel and register defaults.
// A two-entry output (result register plus skid register) accepts one more
// tick while the output stalls; req ready drops only when both are full.
module efis_panel_baro_selector (
   input  wire logic clock,
   input  wire logic reset,
   efis_req_if.sink   req_if,
   efis_rsp_if.source rsp_if,
   efis_csr_if.sink   csr_if
);
   import efis_pkg::*;

   // Registers
   efis_cfg_type cfg_ff;
   logic         fd_on_ff, fd_on_in;
   logic         ls_on_ff, ls_on_in;
   logic [2:0]   filter_ff, filter_in;
   logic         std_on_ff, std_on_in;
   logic         qfe_on_ff, qfe_on_in;
   logic         rsp_valid_ff, skid_valid_ff;
   efis_rsp_type rsp_data_ff, skid_data_ff;

   logic          req_accept, rsp_accept;
   efis_step_type step;
   efis_baro_type baro_cur, baro_nxt;
   efis_rsp_type  result;
   logic [WordWidth-1:0] w1, w2;

   assign req_accept = req_if.valid && req_if.ready;
   assign rsp_accept = rsp_if.valid && rsp_if.ready;
   assign req_if.ready = !skid_valid_ff;
   assign csr_if.ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_hpa                <= MinHpaReset;
         cfg_ff.max_hpa                <= MaxHpaReset;
         cfg_ff.min_inhg_centi         <= MinInhgReset;
         cfg_ff.max_inhg_centi         <= MaxInhgReset;
         cfg_ff.hpa_per_inhg_centi_q16 <= KHpaReset;
         cfg_ff.inhg_centi_per_hpa_q16 <= KInhgReset;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_MIN_HPA:  cfg_ff.min_hpa <= csr_if.data[HpaWidth-1:0];
            CSR_MAX_HPA:  cfg_ff.max_hpa <= csr_if.data[HpaWidth-1:0];
            CSR_MIN_INHG: cfg_ff.min_inhg_centi <= csr_if.data[InhgWidth-1:0];
            CSR_MAX_INHG: cfg_ff.max_inhg_centi <= csr_if.data[InhgWidth-1:0];
            CSR_K_HPA:    cfg_ff.hpa_per_inhg_centi_q16 <= csr_if.data[KHpaWidth-1:0];
            CSR_K_INHG:   cfg_ff.inhg_centi_per_hpa_q16 <= csr_if.data[KInhgWidth-1:0];
            default: ;
         endcase
      end
   end

   // Toggles, filter and baro mode flags
   always_comb begin
      fd_on_in  = fd_on_ff;
      ls_on_in  = ls_on_ff;
      filter_in = filter_ff;
      std_on_in = std_on_ff;
      qfe_on_in = qfe_on_ff;
      if (req_accept) begin
         if (req_if.fd_button) fd_on_in = !fd_on_ff;
         if (req_if.ls_button) ls_on_in = !ls_on_ff;
         if (req_if.filter_button != FILT_NONE && req_if.filter_button <= FILT_ARPT) begin
            filter_in = (req_if.filter_button == filter_ff) ? FILT_NONE
                                                            : req_if.filter_button;
         end
         if (req_if.knob_pull) begin
            std_on_in = 1'b1;
         end else if (req_if.knob_push && std_on_ff) begin
            std_on_in = 1'b0;
         end else if (req_if.knob_push) begin
            qfe_on_in = !qfe_on_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fd_on_ff  <= 1'b1;
         ls_on_ff  <= 1'b0;
         filter_ff <= FILT_NONE;
         std_on_ff <= 1'b0;
         qfe_on_ff <= 1'b0;
      end else begin
         fd_on_ff  <= fd_on_in;
         ls_on_ff  <= ls_on_in;
         filter_ff <= filter_in;
         std_on_ff <= std_on_in;
         qfe_on_ff <= qfe_on_in;
      end
   end

   // Baro setting; held while standard is selected
   assign step = '{en:      req_accept && !std_on_in,
                   dec:     req_if.knob_dec,
                   inc:     req_if.knob_inc,
                   is_inhg: req_if.unit_is_inhg};

   efis_baro_unit u_baro (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .cfg   (cfg_ff),
      .cur   (baro_cur),
      .nxt   (baro_nxt)
   );

   // Discrete words from the updated state
   always_comb begin
      w1 = '0;
      w1[PosSsmHi:PosSsmLo] = SsmNormal;
      w1[PosUnitInhg] = req_if.unit_is_inhg;
      w1[PosRange10]  = (req_if.range_sel == RANGE_10);
      w1[PosRange20]  = (req_if.range_sel == RANGE_20);
      w1[PosRange40]  = (req_if.range_sel == RANGE_40);
      w1[PosRange80]  = (req_if.range_sel == RANGE_80);
      w1[PosRange160] = (req_if.range_sel == RANGE_160);

      w2 = '0;
      w2[PosSsmHi:PosSsmLo] = SsmNormal;
      w2[PosModeIls]  = (req_if.mode_sel == MODE_ROSE_ILS);
      w2[PosModeVor]  = (req_if.mode_sel == MODE_ROSE_VOR);
      w2[PosModeNav]  = (req_if.mode_sel == MODE_ROSE_NAV);
      w2[PosModeArc]  = (req_if.mode_sel == MODE_ARC);
      w2[PosModePlan] = (req_if.mode_sel == MODE_PLAN);
      w2[PosFiltCstr] = (filter_in == FILT_CSTR);
      w2[PosFiltWpt]  = (filter_in == FILT_WPT);
      w2[PosFiltVord] = (filter_in == FILT_VORD);
      w2[PosFiltNdb]  = (filter_in == FILT_NDB);
      w2[PosFiltArpt] = (filter_in == FILT_ARPT);
      w2[PosLsOn]     = ls_on_in;
      w2[PosFdOff]    = !fd_on_in;
      w2[PosNav1Adf]  = (req_if.navaid_one_sel == NAVAID_ADF);
      w2[PosNav2Adf]  = (req_if.navaid_two_sel == NAVAID_ADF);
      w2[PosNav1Vor]  = (req_if.navaid_one_sel == NAVAID_VOR);
      w2[PosNav2Vor]  = (req_if.navaid_two_sel == NAVAID_VOR);
      w2[PosStdOn]    = std_on_in;
      w2[PosQfeOff]   = !qfe_on_in;

      result = '{word_one:      w1,
                 word_two:      w2,
                 baro_hpa_out:  baro_nxt.hpa,
                 baro_inhg_out: baro_nxt.inhg};
   end

   // Output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_if.ready) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= req_accept;
         end
      end else if (req_accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_if.ready) begin
         if (skid_valid_ff) begin
            rsp_data_ff <= skid_data_ff;
         end else if (req_accept) begin
            rsp_data_ff <= result;
         end
      end else if (req_accept) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.word_one      = rsp_data_ff.word_one;
   assign rsp_if.word_two      = rsp_data_ff.word_two;
   assign rsp_if.baro_hpa_out  = rsp_data_ff.baro_hpa_out;
   assign rsp_if.baro_inhg_out = rsp_data_ff.baro_inhg_out;

   // Checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without a result in the output register");

   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_if.ready))
      else $error("skid stage filled while the output was not stalled");

   a_std_holds_baro: assert property (@(posedge clock) disable iff (reset)
      (req_accept && std_on_in) |=> $stable(baro_cur))
      else $error("baro setting moved while standard was selected");

   a_no_tick_no_result: assert property (@(posedge clock) disable iff (reset)
      (!req_accept && !skid_valid_ff && (!rsp_valid_ff || rsp_accept)) |=> !rsp_valid_ff)
      else $error("result presented without an accepted transaction");

endmodule

`default_nettype wire

// ----- rtl/core/efis_baro_unit.sv -----
`default_nettype none

// Baro setting: knob step with clamp in the selected unit, Q16 conversion
// into the other unit. One conversion multiplier shared by both directions.
module efis_baro_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire efis_pkg::efis_step_type step,
   input  wire efis_pkg::efis_cfg_type  cfg,
   output efis_pkg::efis_baro_type      cur,
   output efis_pkg::efis_baro_type      nxt
);
   import efis_pkg::*;

   logic [HpaWidth-1:0]  hpa_ff, hpa_in;
   logic [InhgWidth-1:0] inhg_ff, inhg_in;
   logic [InhgWidth-1:0] stepped;
   logic [InhgWidth-1:0] lo_sel, hi_sel;
   logic [InhgWidth-1:0] mul_val, sat_sel, scaled;
   logic [KHpaWidth-1:0] k_sel;

   function automatic logic [InhgWidth-1:0] clamp_val(
      input logic signed [InhgWidth+1:0] v,
      input logic [InhgWidth-1:0]        lo,
      input logic [InhgWidth-1:0]        hi
   );
      logic signed [InhgWidth+1:0] r;
      r = v;
      if (r < $signed({2'b00, lo})) r = $signed({2'b00, lo});
      if (r > $signed({2'b00, hi})) r = $signed({2'b00, hi});
      return r[InhgWidth-1:0];
   endfunction

   // dec first, then inc, each clamped
   function automatic logic [InhgWidth-1:0] step_clamp(
      input logic [InhgWidth-1:0] v,
      input logic                 dec,
      input logic                 inc,
      input logic [InhgWidth-1:0] lo,
      input logic [InhgWidth-1:0] hi
   );
      logic [InhgWidth-1:0] t;
      t = v;
      if (dec) t = clamp_val($signed({2'b00, t} - 14'd1), lo, hi);
      if (inc) t = clamp_val($signed({2'b00, t} + 14'd1), lo, hi);
      return t;
   endfunction

   // (v * k + 0.5) in Q16, saturated
   function automatic logic [InhgWidth-1:0] q16_scale(
      input logic [InhgWidth-1:0] v,
      input logic [KHpaWidth-1:0] k,
      input logic [InhgWidth-1:0] limit
   );
      logic [InhgWidth+KHpaWidth:0] prod;
      logic [InhgWidth+KHpaWidth-16:0] p;
      prod = {{(KHpaWidth+1){1'b0}}, v} * {{(InhgWidth+1){1'b0}}, k}
             + (InhgWidth+KHpaWidth+1)'(32768);
      p = prod[InhgWidth+KHpaWidth:16];
      return (p > {{(KHpaWidth-15){1'b0}}, limit}) ? limit : p[InhgWidth-1:0];
   endfunction

   // operand selection by unit
   always_comb begin
      if (step.is_inhg) begin
         lo_sel  = cfg.min_inhg_centi;
         hi_sel  = cfg.max_inhg_centi;
         stepped = step_clamp(inhg_ff, step.dec, step.inc, lo_sel, hi_sel);
         k_sel   = cfg.hpa_per_inhg_centi_q16;
         sat_sel = HpaSat;
      end else begin
         lo_sel  = {1'b0, cfg.min_hpa};
         hi_sel  = {1'b0, cfg.max_hpa};
         stepped = step_clamp({1'b0, hpa_ff}, step.dec, step.inc, lo_sel, hi_sel);
         k_sel   = {2'b00, cfg.inhg_centi_per_hpa_q16};
         sat_sel = InhgSat;
      end
      mul_val = stepped;
      scaled  = q16_scale(mul_val, k_sel, sat_sel);
   end

   // next values
   always_comb begin
      hpa_in  = hpa_ff;
      inhg_in = inhg_ff;
      if (step.en) begin
         if (step.is_inhg) begin
            inhg_in = stepped;
            hpa_in  = scaled[HpaWidth-1:0];
         end else begin
            hpa_in  = stepped[HpaWidth-1:0];
            inhg_in = scaled;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hpa_ff  <= HpaStdValue;
         inhg_ff <= InhgStdValue;
      end else begin
         hpa_ff  <= hpa_in;
         inhg_ff <= inhg_in;
      end
   end

   assign cur = '{hpa: hpa_ff, inhg: inhg_ff};
   assign nxt = '{hpa: hpa_in, inhg: inhg_in};

endmodule

`default_nettype wire
